// ===== src/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit sequencer.
// No dependencies; imported by every module of the block except i2cm_fifo.
package i2cm_pkg;

  // Commands carried by an input item
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_B   = 4'd1,
    PH_START_C   = 4'd2,
    PH_STOP_B    = 4'd3,
    PH_STOP_C    = 4'd4,
    PH_WR_HIGH   = 4'd5,
    PH_WR_LOW    = 4'd6,
    PH_WR_NEXT   = 4'd7,
    PH_ACK_HIGH  = 4'd8,
    PH_ACK_CHECK = 4'd9,
    PH_RD_HIGH   = 4'd10,
    PH_RD_NEXT   = 4'd11,
    PH_RP_HIGH   = 4'd12,
    PH_RP_END    = 4'd13
  } phase_e;

  // Configuration register indexes
  typedef enum logic {
    REG_TICKS      = 1'b0,
    REG_POLL_LIMIT = 1'b1
  } reg_idx_e;

  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] TICKS_RESET      = 16'd1;
  localparam logic [7:0]  POLL_LIMIT_RESET = 8'd250;

  // Wait lengths in delay units
  localparam logic [2:0] WAIT_LONG  = 3'd4;
  localparam logic [2:0] WAIT_MID   = 3'd2;
  localparam logic [2:0] WAIT_SHORT = 3'd1;

  // One tick as seen on the input side
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  // Classified tick handed from the front end to the sequencer
  typedef struct packed {
    cmd_e       op;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } seq_item_t;

  // Pin and status snapshot after one tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       timed_out;
  } res_t;

endpackage

// ===== src/i2cm_fifo.sv =====
// Small register FIFO used for the command and result queues.
// Generic in width and depth; no package dependency.
module i2cm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/i2cm_front.sv =====
// Front end: decodes the command field and queues classified ticks.
// Depends on i2cm_pkg and i2cm_fifo.
module i2cm_front import i2cm_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_item_t  item_i,
  output logic      full_o,
  input  logic      pop_i,
  output seq_item_t item_o,
  output logic      valid_o
);

  seq_item_t cls;
  logic      empty;

  // unknown command codes behave as no command
  always_comb begin
    cls.data_byte = item_i.data_byte;
    cls.send_ack  = item_i.send_ack;
    cls.sda_in    = item_i.sda_in;
    unique case (cmd_e'(item_i.command))
      CMD_START: cls.op = CMD_START;
      CMD_STOP:  cls.op = CMD_STOP;
      CMD_WRITE: cls.op = CMD_WRITE;
      CMD_READ:  cls.op = CMD_READ;
      default:   cls.op = CMD_NONE;
    endcase
  end

  i2cm_fifo #(
    .Width($bits(seq_item_t)),
    .Depth(Depth)
  ) u_cmd_q (
    .clk_i,
    .rst_ni,
    .push_i,
    .wdata_i(cls),
    .full_o,
    .pop_i,
    .rdata_o(item_o),
    .empty_o(empty)
  );

  assign valid_o = !empty;

endmodule

// ===== src/i2cm_seq.sv =====
// Back end: the SCL/SDA sequencer, advancing one step per queued tick.
// Depends on i2cm_pkg; holds the configuration registers.
module i2cm_seq import i2cm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                valid_i,
  input  seq_item_t           item_i,
  output logic                pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output res_t                res_o
);

  logic [15:0] ticks_q;
  logic [7:0]  limit_q;

  phase_e      phase_q, phase_d;
  logic [3:0]  bc_q, bc_d;
  logic [15:0] delay_q, delay_d;
  logic [2:0]  unit_q, unit_d;
  logic [7:0]  shift_q, shift_d;
  logic [8:0]  poll_q, poll_d;
  logic        scl_q, scl_d, sda_q, sda_d, drive_q, drive_d;
  logic        ack_q, ack_d, tout_q, tout_d, reply_q, reply_d;
  logic [7:0]  rx_q, rx_d;
  logic        done;
  logic        step;
  logic [15:0] ticks_eff, delay_inc;
  logic [3:0]  bc_inc;
  logic [8:0]  poll_inc;

  assign step       = valid_i && !res_full_i;
  assign pop_o      = step;
  assign res_push_o = step;
  assign ticks_eff  = (ticks_q == '0) ? 16'd1 : ticks_q;
  assign delay_inc  = delay_q + 16'd1;
  assign bc_inc     = bc_q + 4'd1;
  assign poll_inc   = poll_q + 9'd1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= TICKS_RESET;
      limit_q <= POLL_LIMIT_RESET;
    end else if (cfg_we_i) begin
      if (reg_idx_e'(cfg_idx_i) == REG_TICKS) begin
        ticks_q <= cfg_wdata_i;
      end else begin
        limit_q <= cfg_wdata_i[7:0];
      end
    end
  end

  // next state of one tick
  always_comb begin
    phase_d = phase_q;
    bc_d    = bc_q;
    delay_d = delay_q;
    unit_d  = unit_q;
    shift_d = shift_q;
    poll_d  = poll_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    drive_d = drive_q;
    ack_d   = ack_q;
    tout_d  = tout_q;
    reply_d = reply_q;
    rx_d    = rx_q;
    done    = 1'b0;
    if (phase_q == PH_IDLE) begin
      if (item_i.op != CMD_NONE) begin
        ack_d  = 1'b0;
        tout_d = 1'b0;
      end
      unique case (item_i.op)
        CMD_START: begin
          drive_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
          unit_d = WAIT_LONG; delay_d = '0; phase_d = PH_START_B;
        end
        CMD_STOP: begin
          drive_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
          unit_d = WAIT_LONG; delay_d = '0; phase_d = PH_STOP_B;
        end
        CMD_WRITE: begin
          shift_d = item_i.data_byte; bc_d = '0;
          drive_d = 1'b1; sda_d = item_i.data_byte[7];
          unit_d = WAIT_SHORT; delay_d = '0; phase_d = PH_WR_HIGH;
        end
        CMD_READ: begin
          reply_d = item_i.send_ack;
          drive_d = 1'b0; scl_d = 1'b0; shift_d = '0; bc_d = '0;
          unit_d = WAIT_MID; delay_d = '0; phase_d = PH_RD_HIGH;
        end
        default: ;
      endcase
    end else begin
      // count down the pending wait
      if (unit_q != '0) begin
        if (delay_inc >= ticks_eff) begin
          delay_d = '0;
          unit_d  = unit_q - 3'd1;
        end else begin
          delay_d = delay_inc;
        end
      end
      // pin action once the wait is over
      if (unit_d == '0) begin
        unique case (phase_q)
          PH_START_B: begin
            sda_d = 1'b0; unit_d = WAIT_LONG; delay_d = '0; phase_d = PH_START_C;
          end
          PH_START_C: begin
            scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
          end
          PH_STOP_B: begin
            scl_d = 1'b1; sda_d = 1'b1;
            unit_d = WAIT_LONG; delay_d = '0; phase_d = PH_STOP_C;
          end
          PH_STOP_C: begin
            phase_d = PH_IDLE; done = 1'b1;
          end
          PH_WR_HIGH: begin
            scl_d = 1'b1; unit_d = WAIT_MID; delay_d = '0; phase_d = PH_WR_LOW;
          end
          PH_WR_LOW: begin
            scl_d = 1'b0; unit_d = WAIT_SHORT; delay_d = '0; phase_d = PH_WR_NEXT;
          end
          PH_WR_NEXT: begin
            bc_d = bc_inc;
            if (!bc_inc[3]) begin
              sda_d = shift_q[3'd7 - bc_inc[2:0]];
              unit_d = WAIT_SHORT; delay_d = '0; phase_d = PH_WR_HIGH;
            end else begin
              // release SDA for the acknowledge bit
              drive_d = 1'b0; sda_d = 1'b1; poll_d = '0;
              unit_d = WAIT_SHORT; delay_d = '0; phase_d = PH_ACK_HIGH;
            end
          end
          PH_ACK_HIGH: begin
            scl_d = 1'b1; unit_d = WAIT_SHORT; delay_d = '0; phase_d = PH_ACK_CHECK;
          end
          PH_ACK_CHECK: begin
            if (!item_i.sda_in) begin
              scl_d = 1'b0; ack_d = 1'b1; phase_d = PH_IDLE; done = 1'b1;
            end else begin
              poll_d = poll_inc;
              if (poll_inc > {1'b0, limit_q}) begin
                // no acknowledge in time: send stop
                tout_d = 1'b1;
                drive_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
                unit_d = WAIT_LONG; delay_d = '0; phase_d = PH_STOP_B;
              end
            end
          end
          PH_RD_HIGH: begin
            scl_d = 1'b1;
            shift_d = {shift_q[6:0], item_i.sda_in};
            bc_d = bc_inc;
            unit_d = WAIT_SHORT; delay_d = '0; phase_d = PH_RD_NEXT;
          end
          PH_RD_NEXT: begin
            scl_d = 1'b0;
            if (!bc_q[3]) begin
              unit_d = WAIT_MID; delay_d = '0; phase_d = PH_RD_HIGH;
            end else begin
              drive_d = 1'b1; sda_d = !reply_q;
              unit_d = WAIT_MID; delay_d = '0; phase_d = PH_RP_HIGH;
            end
          end
          PH_RP_HIGH: begin
            scl_d = 1'b1; unit_d = WAIT_MID; delay_d = '0; phase_d = PH_RP_END;
          end
          PH_RP_END: begin
            scl_d = 1'b0; rx_d = shift_q; phase_d = PH_IDLE; done = 1'b1;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // result of this tick
  always_comb begin
    res_o.scl_level    = scl_d;
    res_o.sda_level    = sda_d;
    res_o.sda_drive    = drive_d;
    res_o.busy_res     = (phase_d != PH_IDLE);
    res_o.done_res     = done;
    res_o.rx_byte      = rx_d;
    res_o.ack_received = ack_d;
    res_o.timed_out    = tout_d;
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bc_q    <= '0;
      delay_q <= '0;
      unit_q  <= '0;
      shift_q <= '0;
      poll_q  <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drive_q <= 1'b1;
      ack_q   <= 1'b0;
      tout_q  <= 1'b0;
      reply_q <= 1'b0;
      rx_q    <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      delay_q <= delay_d;
      unit_q  <= unit_d;
      shift_q <= shift_d;
      poll_q  <= poll_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drive_q <= drive_d;
      ack_q   <= ack_d;
      tout_q  <= tout_d;
      reply_q <= reply_d;
      rx_q    <= rx_d;
    end
  end

endmodule

// ===== src/i2c_master_bit_sequencer_top.sv =====
// I2C master bit sequencer, top level.
// Depends on i2cm_pkg, i2cm_front, i2cm_seq and i2cm_fifo.

// Each accepted item is one clock tick of the I2C master: it carries the
// sampled SDA level and, while no sequence runs, a command (start, stop,
// write byte, read byte). Every tick yields exactly one result with the
// SCL/SDA levels, SDA drive enable and status after that tick. The block
// sustains one tick per clock while the result FIFO has room: ticks queue in
// a short command FIFO, the sequencer consumes one per clock from its head
// unless the result FIFO is full, and each result is written into a result
// FIFO when its tick is consumed, from which it can then be popped.
// Either side may stall without losing ticks; the queues are QueueDepth deep.
// Configuration (register 0: ticks per delay unit, register 1: acknowledge
// poll limit) must be written only while no ticks are in flight.
module i2c_master_bit_sequencer_top import i2cm_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_i,
  output logic                empty,
  input  logic                pop,
  output res_t                res_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  seq_item_t seq_item;
  logic      seq_valid, seq_pop;
  logic      res_push, res_full;
  res_t      seq_res;

  i2cm_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .item_i (in_i),
    .full_o (full),
    .pop_i  (seq_pop),
    .item_o (seq_item),
    .valid_o(seq_valid)
  );

  i2cm_seq u_seq (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .valid_i   (seq_valid),
    .item_i    (seq_item),
    .pop_o     (seq_pop),
    .res_full_i(res_full),
    .res_push_o(res_push),
    .res_o     (seq_res)
  );

  i2cm_fifo #(
    .Width($bits(res_t)),
    .Depth(QueueDepth)
  ) u_res_q (
    .clk_i,
    .rst_ni,
    .push_i (res_push),
    .wdata_i(seq_res),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_o),
    .empty_o(empty)
  );

`ifndef NO_ASSERTIONS
  // a finishing tick never reports a sequence still running
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && res_o.done_res |-> !res_o.busy_res)
    else $error("done_res with busy_res set");

  // acknowledge and timeout never reported together
  a_ack_xor_tout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(res_o.ack_received && res_o.timed_out))
    else $error("ack_received and timed_out both set");

  // an accepted tick is queued for the sequencer on the next clock
  a_push_reaches_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> seq_valid)
    else $error("accepted tick missing from command queue");
`endif

endmodule

// ===== tb/i2c_master_bit_sequencer_checker.sv =====
// Transfer monitor and pin-level predictor for the I2C master bit sequencer.
// Depends on i2cm_pkg; instantiated beside the block by the testbench top.
module i2c_master_bit_sequencer_checker import i2cm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  in_item_t            item_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  res_t                res_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                seq_busy_o,
  output int unsigned         outstanding_o,
  output int unsigned         mismatch_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Configuration copy
  logic [15:0] ticks_cfg;
  logic [7:0]  poll_limit;

  // Sequencer state copy
  phase_e      seq_phase;
  logic [3:0]  bit_cnt;
  logic [15:0] tick_cnt;
  logic [2:0]  unit_cnt;
  logic [7:0]  shreg;
  logic [8:0]  poll_cnt;
  logic        scl_q, sda_q, drv_q;
  logic        ack_flag, tmo_flag, reply_flag;
  logic [7:0]  rx_hold;

  // Pin/status snapshots still to come out of the block, oldest first
  res_t snapshot_q[$];

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatch_cnt_o++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic reset_model();
    ticks_cfg  = TICKS_RESET;
    poll_limit = POLL_LIMIT_RESET;
    seq_phase  = PH_IDLE;
    bit_cnt    = '0;
    tick_cnt   = '0;
    unit_cnt   = '0;
    shreg      = '0;
    poll_cnt   = '0;
    scl_q      = 1'b1;
    sda_q      = 1'b1;
    drv_q      = 1'b1;
    ack_flag   = 1'b0;
    tmo_flag   = 1'b0;
    reply_flag = 1'b0;
    rx_hold    = '0;
  endtask

  task automatic load_wait(input logic [2:0] units, input phase_e nxt);
    unit_cnt  = units;
    tick_cnt  = '0;
    seq_phase = nxt;
  endtask

  // First half of the stop condition: both lines low
  task automatic begin_stop();
    drv_q = 1'b1;
    scl_q = 1'b0;
    sda_q = 1'b0;
    load_wait(WAIT_LONG, PH_STOP_B);
  endtask

  // Pin action at the end of a wait; fin is set when the sequence completes
  task automatic run_phase(input logic sda_in, output logic fin);
    fin = 1'b0;
    case (seq_phase)
      PH_START_B: begin
        sda_q = 1'b0;
        load_wait(WAIT_LONG, PH_START_C);
      end
      PH_START_C: begin
        scl_q     = 1'b0;
        seq_phase = PH_IDLE;
        fin       = 1'b1;
      end
      PH_STOP_B: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
        load_wait(WAIT_LONG, PH_STOP_C);
      end
      PH_STOP_C: begin
        seq_phase = PH_IDLE;
        fin       = 1'b1;
      end
      PH_WR_HIGH: begin
        scl_q = 1'b1;
        load_wait(WAIT_MID, PH_WR_LOW);
      end
      PH_WR_LOW: begin
        scl_q = 1'b0;
        load_wait(WAIT_SHORT, PH_WR_NEXT);
      end
      PH_WR_NEXT: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt < 4'd8) begin
          sda_q = shreg[3'd7 - bit_cnt[2:0]];
          load_wait(WAIT_SHORT, PH_WR_HIGH);
        end else begin
          // release SDA for the slave acknowledge
          drv_q    = 1'b0;
          sda_q    = 1'b1;
          poll_cnt = '0;
          load_wait(WAIT_SHORT, PH_ACK_HIGH);
        end
      end
      PH_ACK_HIGH: begin
        scl_q = 1'b1;
        load_wait(WAIT_SHORT, PH_ACK_CHECK);
      end
      PH_ACK_CHECK: begin
        if (!sda_in) begin
          scl_q     = 1'b0;
          ack_flag  = 1'b1;
          seq_phase = PH_IDLE;
          fin       = 1'b1;
        end else begin
          // one poll per tick until the limit is passed
          poll_cnt = poll_cnt + 9'd1;
          if (poll_cnt > {1'b0, poll_limit}) begin
            tmo_flag = 1'b1;
            begin_stop();
          end
        end
      end
      PH_RD_HIGH: begin
        scl_q   = 1'b1;
        shreg   = {shreg[6:0], sda_in};
        bit_cnt = bit_cnt + 4'd1;
        load_wait(WAIT_SHORT, PH_RD_NEXT);
      end
      PH_RD_NEXT: begin
        scl_q = 1'b0;
        if (bit_cnt < 4'd8) begin
          load_wait(WAIT_MID, PH_RD_HIGH);
        end else begin
          // drive ACK (low) or NACK (high)
          drv_q = 1'b1;
          sda_q = !reply_flag;
          load_wait(WAIT_MID, PH_RP_HIGH);
        end
      end
      PH_RP_HIGH: begin
        scl_q = 1'b1;
        load_wait(WAIT_MID, PH_RP_END);
      end
      PH_RP_END: begin
        scl_q     = 1'b0;
        rx_hold   = shreg;
        seq_phase = PH_IDLE;
        fin       = 1'b1;
      end
      default: seq_phase = PH_IDLE;
    endcase
  endtask

  // One tick of the sequencer: command decode when idle, else wait and act
  task automatic advance_tick(input in_item_t it, output res_t snap);
    logic [15:0] unit_len;
    logic        fin;
    unit_len = (ticks_cfg == '0) ? 16'd1 : ticks_cfg;
    fin      = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (it.command >= CMD_START && it.command <= CMD_READ) begin
        ack_flag = 1'b0;
        tmo_flag = 1'b0;
      end
      case (it.command)
        CMD_START: begin
          drv_q = 1'b1;
          sda_q = 1'b1;
          scl_q = 1'b1;
          load_wait(WAIT_LONG, PH_START_B);
        end
        CMD_STOP: begin_stop();
        CMD_WRITE: begin
          shreg   = it.data_byte;
          bit_cnt = '0;
          drv_q   = 1'b1;
          sda_q   = it.data_byte[7];
          load_wait(WAIT_SHORT, PH_WR_HIGH);
        end
        CMD_READ: begin
          reply_flag = it.send_ack;
          drv_q      = 1'b0;
          scl_q      = 1'b0;
          shreg      = '0;
          bit_cnt    = '0;
          load_wait(WAIT_MID, PH_RD_HIGH);
        end
        default: ;
      endcase
    end else begin
      if (unit_cnt != '0) begin
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= unit_len) begin
          tick_cnt = '0;
          unit_cnt = unit_cnt - 3'd1;
        end
      end
      if (unit_cnt == '0) run_phase(it.sda_in, fin);
    end
    snap.scl_level    = scl_q;
    snap.sda_level    = sda_q;
    snap.sda_drive    = drv_q;
    snap.busy_res     = (seq_phase != PH_IDLE);
    snap.done_res     = fin;
    snap.rx_byte      = rx_hold;
    snap.ack_received = ack_flag;
    snap.timed_out    = tmo_flag;
  endtask

  // Watch the configuration port and both transfer channels
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t want;
    res_t snap;
    if (!rst_ni) begin
      reset_model();
      snapshot_q.delete();
      mismatch_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_TICKS) ticks_cfg = cfg_wdata_i;
        else poll_limit = cfg_wdata_i[7:0];
      end
      if (pop_i && !empty_i) begin
        if (snapshot_q.size() == 0) begin
          flag_mismatch("result transfer with nothing expected");
        end else begin
          want = snapshot_q.pop_front();
          compare_field("scl_level", 8'(res_i.scl_level), 8'(want.scl_level));
          compare_field("sda_level", 8'(res_i.sda_level), 8'(want.sda_level));
          compare_field("sda_drive", 8'(res_i.sda_drive), 8'(want.sda_drive));
          compare_field("busy_res", 8'(res_i.busy_res), 8'(want.busy_res));
          compare_field("done_res", 8'(res_i.done_res), 8'(want.done_res));
          compare_field("rx_byte", res_i.rx_byte, want.rx_byte);
          compare_field("ack_received", 8'(res_i.ack_received), 8'(want.ack_received));
          compare_field("timed_out", 8'(res_i.timed_out), 8'(want.timed_out));
        end
      end
      if (push_i && !full_i) begin
        advance_tick(item_i, snap);
        snapshot_q.push_back(snap);
      end
    end
    outstanding_o = snapshot_q.size();
    seq_busy_o    = (seq_phase != PH_IDLE);
  end

endmodule

// ===== tb/tb_i2c_master_bit_sequencer_top.sv =====
// Testbench top for the I2C master bit sequencer: clock, reset, tick stimulus,
// configuration phases and the verdict. Depends on i2cm_pkg, the block and
// i2c_master_bit_sequencer_checker.
module tb_i2c_master_bit_sequencer_top;
  import i2cm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3_000_000;

  // How the sampled SDA level behaves on the ticks after a command
  typedef enum {SDA_RANDOM, SDA_HIGH, SDA_LOW, SDA_SPARSE_LOW} sda_mode_e;

  logic                clk_i;
  logic                rst_n;
  logic                push;
  logic                full;
  in_item_t            in_item;
  logic                empty;
  logic                pop;
  res_t                res;
  logic                cfg_we;
  logic                cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  logic        seq_busy;
  int unsigned outstanding;
  int unsigned mismatch_cnt;

  int unsigned n_items = 0;
  int unsigned cycle_cnt = 0;
  bit          no_idle = 1'b0;
  sda_mode_e   sda_mode = SDA_RANDOM;

  i2c_master_bit_sequencer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .in_i        (in_item),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  i2c_master_bit_sequencer_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .push_i         (push),
    .full_i         (full),
    .item_i         (in_item),
    .empty_i        (empty),
    .pop_i          (pop),
    .res_i          (res),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .seq_busy_o     (seq_busy),
    .outstanding_o  (outstanding),
    .mismatch_cnt_o (mismatch_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random pop, one long hold-off so the input backs up
  initial begin : result_side
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    pop       = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk_i);
      if (!held && n_items >= 150) begin
        held      = 1'b1;
        hold_left = 120;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(99) >= 33);
      end
    end
  end

  // Tick while a sequence runs: stray commands are ignored by the block
  function automatic in_item_t filler_tick();
    in_item_t t;
    t.command   = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : CMD_NONE;
    t.data_byte = 8'($urandom);
    t.send_ack  = 1'($urandom);
    case (sda_mode)
      SDA_HIGH:       t.sda_in = 1'b1;
      SDA_LOW:        t.sda_in = 1'b0;
      SDA_SPARSE_LOW: t.sda_in = ($urandom_range(15) != 0);
      default:        t.sda_in = 1'($urandom);
    endcase
    return t;
  endfunction

  function automatic sda_mode_e pick_mode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return SDA_RANDOM;
    if (r < 65) return SDA_SPARSE_LOW;
    if (r < 85) return SDA_LOW;
    return SDA_HIGH;
  endfunction

  // Offer one tick from a falling edge; returns at the falling edge after
  // its transfer
  task automatic send_tick(input in_item_t it);
    while (!no_idle && $urandom_range(99) < 33) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    n_items++;
    @(negedge clk_i);
  endtask

  // Run out the current sequence, then hand over one command tick
  task automatic issue(input logic [2:0] cmd, input logic [7:0] data,
                       input logic ack_req, input sda_mode_e mode);
    in_item_t t;
    while (seq_busy) send_tick(filler_tick());
    sda_mode    = mode;
    t           = filler_tick();
    t.command   = cmd;
    t.data_byte = data;
    t.send_ack  = ack_req;
    send_tick(t);
  endtask

  // Finish the running sequence and drain every outstanding result
  task automatic settle();
    while (seq_busy) send_tick(filler_tick());
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic program_cfg(input logic [15:0] ticks, input logic [7:0] limit);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_TICKS;
    cfg_wdata <= ticks;
    @(negedge clk_i);
    cfg_idx   <= REG_POLL_LIMIT;
    cfg_wdata <= {8'd0, limit};
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly well-formed transactions, some lone or unknown commands
  task automatic random_sequence();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 75) begin
      issue(CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM);
      n = $urandom_range(1, 3);
      repeat (n) issue(CMD_WRITE, 8'($urandom), 1'($urandom), pick_mode());
      n = $urandom_range(0, 2);
      repeat (n) issue(CMD_READ, 8'($urandom), 1'($urandom), pick_mode());
      if ($urandom_range(9) != 0) issue(CMD_STOP, 8'($urandom), 1'($urandom), pick_mode());
    end else begin
      issue(3'($urandom_range(7)), 8'($urandom), 1'($urandom), pick_mode());
    end
  endtask

  task automatic random_phase(input logic [15:0] ticks, input logic [7:0] limit,
                              input int unsigned quota);
    int unsigned stop_at;
    program_cfg(ticks, limit);
    stop_at = n_items + quota;
    while (n_items < stop_at) random_sequence();
    settle();
  endtask

  initial begin : stimulus
    push      = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_TICKS;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed, reset configuration: no-op and unknown commands at idle
    issue(CMD_NONE, 8'h00, 1'b0, SDA_RANDOM);
    issue(3'd5, 8'hFF, 1'b1, SDA_RANDOM);
    issue(3'd7, 8'h00, 1'b0, SDA_RANDOM);
    // write with quick acknowledge, late acknowledge, and poll timeout
    issue(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
    issue(CMD_WRITE, 8'hFF, 1'b1, SDA_LOW);
    issue(CMD_WRITE, 8'h00, 1'b0, SDA_SPARSE_LOW);
    issue(CMD_WRITE, 8'hA5, 1'b1, SDA_HIGH);
    // reads of all ones with ACK, all zeros with NACK, random data
    issue(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
    issue(CMD_READ, 8'h00, 1'b1, SDA_HIGH);
    issue(CMD_READ, 8'hFF, 1'b0, SDA_LOW);
    issue(CMD_READ, 8'h3C, 1'b1, SDA_RANDOM);
    issue(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
    issue(CMD_STOP, 8'hFF, 1'b1, SDA_RANDOM);
    settle();

    // Zero ticks per unit behaves as one; zero poll limit times out at once
    program_cfg(16'd0, 8'd0);
    issue(CMD_WRITE, 8'h5A, 1'b0, SDA_HIGH);
    issue(CMD_WRITE, 8'h81, 1'b1, SDA_LOW);
    issue(CMD_READ, 8'h00, 1'b0, SDA_RANDOM);
    settle();

    // Random phases over several settings
    random_phase(16'd1, 8'd3, 100);
    random_phase(16'd2, 8'd255, 100);
    random_phase(16'd0, 8'd0, 100);

    // Both sides without gaps: one random phase, then a long delay unit
    no_idle = 1'b1;
    random_phase(16'($urandom_range(1, 3)), 8'($urandom_range(31)), 100);
    program_cfg(16'd16, 8'($urandom));
    issue(CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM);
    settle();
    repeat (10) @(negedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
